### rtl/mrt_pkg.sv
package mrt_pkg;

    // Region type code that marks a region as available
    localparam logic [31:0] TYPE_AVAILABLE = 32'd1;

    // Reset value of the kernel floor register
    localparam logic [63:0] KERNEL_FLOOR_RESET = 64'h0000_0000_0010_0000;

    // Command codes; codes 6 and 7 do nothing
    typedef enum logic [2:0] {
        CMD_APPEND  = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_READ    = 3'd2,
        CMD_RANGE   = 3'd3,
        CMD_LARGEST = 3'd4,
        CMD_KERNEL  = 3'd5
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_NOENT = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_DRAIN,
        S_RESP
    } state_t;

    // One table slot
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] len;
        logic [31:0] rtype;
    } entry_t;

    // Candidate from the entry evaluator
    typedef struct packed {
        logic        busy;
        logic        valid;
        logic        hit;
        logic [63:0] base;
        logic [63:0] len;
    } cand_t;

endpackage

### rtl/mrt_eval.sv
module mrt_eval (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  mrt_pkg::entry_t      in_entry,
    input  mrt_pkg::cmd_t        mode,
    input  logic [63:0]          q_base,
    input  logic [63:0]          q_end,
    input  logic [63:0]          floor,
    output mrt_pkg::cand_t       cand
);

    logic            s1_valid_reg;
    mrt_pkg::entry_t s1_entry_reg;
    logic [64:0]     s1_end_reg;
    logic [64:0]     s1_end_next;

    logic            c_valid_reg;
    logic            c_hit_reg;
    logic [63:0]     c_base_reg;
    logic [63:0]     c_len_reg;
    logic            c_hit_next;
    logic [63:0]     c_base_next;
    logic [63:0]     c_len_next;

    logic            avail;
    logic [63:0]     end_wrap;

    // Stage one: full-width end of the slot
    assign s1_end_next = {1'b0, in_entry.base} + {1'b0, in_entry.len};

    // Stage two: qualify the slot and, for kernel region, clip it to the floor
    always_comb begin
        avail       = (s1_entry_reg.rtype == mrt_pkg::TYPE_AVAILABLE);
        end_wrap    = s1_end_reg[63:0];
        c_hit_next  = 1'b0;
        c_base_next = s1_entry_reg.base;
        c_len_next  = s1_entry_reg.len;
        unique case (mode)
            mrt_pkg::CMD_RANGE: begin
                c_hit_next = avail && (q_base >= s1_entry_reg.base) && (q_end <= end_wrap);
            end
            mrt_pkg::CMD_KERNEL: begin
                if (!avail || (end_wrap <= floor)) begin
                    c_hit_next = 1'b0;
                end else if (s1_entry_reg.base < floor) begin
                    // slot straddles the floor: keep only the part above it
                    if ({1'b0, floor} >= s1_end_reg) begin
                        c_hit_next = 1'b0;
                    end else begin
                        c_hit_next  = 1'b1;
                        c_base_next = floor;
                        c_len_next  = end_wrap - floor;
                    end
                end else begin
                    c_hit_next = 1'b1;
                end
            end
            default: begin
                c_hit_next = avail;
            end
        endcase
    end

    // Advance valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            c_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            c_valid_reg  <= s1_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        s1_entry_reg <= in_entry;
        s1_end_reg   <= s1_end_next;
        c_hit_reg    <= c_hit_next;
        c_base_reg   <= c_base_next;
        c_len_reg    <= c_len_next;
    end

    assign cand.busy  = s1_valid_reg || c_valid_reg;
    assign cand.valid = c_valid_reg;
    assign cand.hit   = c_hit_reg;
    assign cand.base  = c_base_reg;
    assign cand.len   = c_len_reg;

endmodule

### rtl/memory_region_table_core.sv
// Memory region table. Holds up to ENTRIES regions (base, length, type) in one
// single-port-read memory and keeps the running top of memory and available
// total. After reset the block clears the memory, one slot per cycle, with
// s_ready low; kernel_floor may be written at any time. Append, write at
// index and unused commands go from the execute state straight to the
// response state; read entry of a present slot passes a read-wait state first.
// Range check, largest region and kernel region walk slots 0 to count-1
// through the memory read port, one slot per cycle, then drain a three-stage
// compare pipeline. One item is worked at a time; the next item may be accepted
// while the previous result still waits on the output register.
module memory_region_table_core #(
    parameter int ENTRIES = 128
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,

    input  logic         s_valid,
    output logic         s_ready,
    input  logic [2:0]   s_command,
    input  logic [7:0]   s_entry_index,
    input  logic [63:0]  s_addr_base,
    input  logic [63:0]  s_region_length,
    input  logic [31:0]  s_region_type,

    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_status,
    output logic         m_found,
    output logic [63:0]  m_result_base,
    output logic [63:0]  m_result_length,
    output logic [31:0]  m_result_type,
    output logic [7:0]   m_entry_count,
    output logic [63:0]  m_total_memory,
    output logic [63:0]  m_available_memory
);

    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Slot memory
    mrt_pkg::entry_t mem [ENTRIES];
    mrt_pkg::entry_t rd_data_reg;
    logic            rd_valid_reg;
    logic            rd_issue;
    logic [IDXW-1:0] rd_addr;
    logic            wr_en;
    logic [IDXW-1:0] wr_addr;
    mrt_pkg::entry_t wr_data;

    // Control state
    mrt_pkg::state_t state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [63:0]     top_reg, top_next;
    logic [63:0]     avail_reg, avail_next;
    logic [63:0]     floor_reg, floor_next;
    logic [IDXW-1:0] clr_idx_reg, clr_idx_next;
    logic [IDXW-1:0] scan_idx_reg, scan_idx_next;
    logic            m_valid_reg, m_valid_next;

    // Captured item
    mrt_pkg::cmd_t   q_cmd_reg, q_cmd_next;
    logic [7:0]      q_idx_reg, q_idx_next;
    logic [63:0]     q_base_reg, q_base_next;
    logic [63:0]     q_len_reg, q_len_next;
    logic [31:0]     q_type_reg, q_type_next;
    logic [63:0]     q_end_reg, q_end_next;

    // Working result
    mrt_pkg::status_t res_status_reg, res_status_next;
    logic             res_found_reg, res_found_next;
    logic [63:0]      res_base_reg, res_base_next;
    logic [63:0]      res_len_reg, res_len_next;
    logic [31:0]      res_type_reg, res_type_next;

    // Output register
    mrt_pkg::status_t m_status_reg, m_status_next;
    logic             m_found_reg, m_found_next;
    logic [63:0]      m_base_reg, m_base_next;
    logic [63:0]      m_len_reg, m_len_next;
    logic [31:0]      m_type_reg, m_type_next;
    logic [7:0]       m_count_reg, m_count_next;
    logic [63:0]      m_top_reg, m_top_next;
    logic [63:0]      m_avail_reg, m_avail_next;

    // Widened views for compares and address slicing
    logic [15:0] idx16, cnt16, idx_inc16, scan_inc16, clr16;
    logic [63:0] app_end;

    mrt_pkg::cand_t cand;

    assign idx16      = 16'(q_idx_reg);
    assign cnt16      = 16'(count_reg);
    assign idx_inc16  = idx16 + 16'd1;
    assign scan_inc16 = 16'(scan_idx_reg) + 16'd1;
    assign clr16      = 16'(clr_idx_reg);
    assign app_end    = q_base_reg + q_len_reg;

    // Shared slot evaluator
    mrt_eval u_eval (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_valid_reg),
        .in_entry (rd_data_reg),
        .mode     (q_cmd_reg),
        .q_base   (q_base_reg),
        .q_end    (q_end_reg),
        .floor    (floor_reg),
        .cand     (cand)
    );

    assign s_ready = (state_reg == mrt_pkg::S_IDLE);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        top_next        = top_reg;
        avail_next      = avail_reg;
        floor_next      = cfg_we ? cfg_wdata : floor_reg;
        clr_idx_next    = clr_idx_reg;
        scan_idx_next   = scan_idx_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        q_cmd_next      = q_cmd_reg;
        q_idx_next      = q_idx_reg;
        q_base_next     = q_base_reg;
        q_len_next      = q_len_reg;
        q_type_next     = q_type_reg;
        q_end_next      = q_end_reg;

        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_base_next   = res_base_reg;
        res_len_next    = res_len_reg;
        res_type_next   = res_type_reg;

        m_status_next   = m_status_reg;
        m_found_next    = m_found_reg;
        m_base_next     = m_base_reg;
        m_len_next      = m_len_reg;
        m_type_next     = m_type_reg;
        m_count_next    = m_count_reg;
        m_top_next      = m_top_reg;
        m_avail_next    = m_avail_reg;

        wr_en    = 1'b0;
        wr_addr  = clr_idx_reg;
        wr_data  = '0;
        rd_addr  = scan_idx_reg;
        rd_issue = 1'b0;

        unique case (state_reg)
            mrt_pkg::S_CLEAR: begin
                wr_en = 1'b1;
                if (clr16 == 16'(ENTRIES - 1)) begin
                    state_next = mrt_pkg::S_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            mrt_pkg::S_IDLE: begin
                if (s_valid) begin
                    q_cmd_next      = mrt_pkg::cmd_t'(s_command);
                    q_idx_next      = s_entry_index;
                    q_base_next     = s_addr_base;
                    q_len_next      = s_region_length;
                    q_type_next     = s_region_type;
                    q_end_next      = s_addr_base + s_region_length;
                    res_status_next = mrt_pkg::STAT_OK;
                    res_found_next  = 1'b0;
                    res_base_next   = '0;
                    res_len_next    = '0;
                    res_type_next   = '0;
                    state_next      = mrt_pkg::S_EXEC;
                end
            end
            mrt_pkg::S_EXEC: begin
                state_next = mrt_pkg::S_RESP;
                unique case (q_cmd_reg)
                    mrt_pkg::CMD_APPEND: begin
                        if (cnt16 >= 16'(ENTRIES)) begin
                            res_status_next = mrt_pkg::STAT_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = cnt16[IDXW-1:0];
                            wr_data    = '{base: q_base_reg, len: q_len_reg,
                                           rtype: q_type_reg};
                            count_next = count_reg + 1'b1;
                            if (q_type_reg == mrt_pkg::TYPE_AVAILABLE) begin
                                avail_next = avail_reg + q_len_reg;
                            end
                            if (app_end > top_reg) begin
                                top_next = app_end;
                            end
                        end
                    end
                    mrt_pkg::CMD_WRITE: begin
                        if (idx16 >= 16'(ENTRIES)) begin
                            res_status_next = mrt_pkg::STAT_RANGE;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = idx16[IDXW-1:0];
                            wr_data = '{base: q_base_reg, len: q_len_reg,
                                        rtype: q_type_reg};
                            if (idx16 >= cnt16) begin
                                count_next = idx_inc16[CNTW-1:0];
                            end
                        end
                    end
                    mrt_pkg::CMD_READ: begin
                        if (idx16 < cnt16) begin
                            rd_addr    = idx16[IDXW-1:0];
                            state_next = mrt_pkg::S_RDWAIT;
                        end else begin
                            res_status_next = mrt_pkg::STAT_NOENT;
                        end
                    end
                    mrt_pkg::CMD_RANGE,
                    mrt_pkg::CMD_LARGEST,
                    mrt_pkg::CMD_KERNEL: begin
                        scan_idx_next = '0;
                        if (cnt16 != 16'd0) begin
                            state_next = mrt_pkg::S_SCAN;
                        end
                    end
                    default: begin
                        state_next = mrt_pkg::S_RESP;
                    end
                endcase
            end
            mrt_pkg::S_RDWAIT: begin
                res_found_next = 1'b1;
                res_base_next  = rd_data_reg.base;
                res_len_next   = rd_data_reg.len;
                res_type_next  = rd_data_reg.rtype;
                state_next     = mrt_pkg::S_RESP;
            end
            mrt_pkg::S_SCAN: begin
                // issue one slot read per cycle
                rd_issue = 1'b1;
                if (scan_inc16 == cnt16) begin
                    state_next = mrt_pkg::S_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            mrt_pkg::S_DRAIN: begin
                if (!rd_valid_reg && !cand.busy) begin
                    state_next = mrt_pkg::S_RESP;
                end
            end
            mrt_pkg::S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_found_next  = res_found_reg;
                    m_base_next   = res_base_reg;
                    m_len_next    = res_len_reg;
                    m_type_next   = res_type_reg;
                    m_count_next  = cnt16[7:0];
                    m_top_next    = top_reg;
                    m_avail_next  = avail_reg;
                    state_next    = mrt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mrt_pkg::S_IDLE;
            end
        endcase

        // Fold each evaluated slot into the running answer; ties keep the first
        if (cand.valid && cand.hit) begin
            if (q_cmd_reg == mrt_pkg::CMD_RANGE) begin
                res_found_next = 1'b1;
            end else if (cand.len > res_len_reg) begin
                res_found_next = 1'b1;
                res_base_next  = cand.base;
                res_len_next   = cand.len;
            end
        end
    end

    // Slot memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mrt_pkg::S_CLEAR;
            count_reg    <= '0;
            top_reg      <= '0;
            avail_reg    <= '0;
            floor_reg    <= mrt_pkg::KERNEL_FLOOR_RESET;
            clr_idx_reg  <= '0;
            scan_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            top_reg      <= top_next;
            avail_reg    <= avail_next;
            floor_reg    <= floor_next;
            clr_idx_reg  <= clr_idx_next;
            scan_idx_reg <= scan_idx_next;
            m_valid_reg  <= m_valid_next;
            rd_valid_reg <= rd_issue;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        q_cmd_reg      <= q_cmd_next;
        q_idx_reg      <= q_idx_next;
        q_base_reg     <= q_base_next;
        q_len_reg      <= q_len_next;
        q_type_reg     <= q_type_next;
        q_end_reg      <= q_end_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_base_reg   <= res_base_next;
        res_len_reg    <= res_len_next;
        res_type_reg   <= res_type_next;
        m_status_reg   <= m_status_next;
        m_found_reg    <= m_found_next;
        m_base_reg     <= m_base_next;
        m_len_reg      <= m_len_next;
        m_type_reg     <= m_type_next;
        m_count_reg    <= m_count_next;
        m_top_reg      <= m_top_next;
        m_avail_reg    <= m_avail_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_found            = m_found_reg;
    assign m_result_base      = m_base_reg;
    assign m_result_length    = m_len_reg;
    assign m_result_type      = m_type_reg;
    assign m_entry_count      = m_count_reg;
    assign m_total_memory     = m_top_reg;
    assign m_available_memory = m_avail_reg;

    // Slot count never passes the table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt16 <= 16'(ENTRIES))
        else $error("slot count exceeds table size");

    // No item is taken during the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mrt_pkg::S_CLEAR) |-> !s_ready)
        else $error("item accepted while clearing");

    // A result appears only out of the response state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == mrt_pkg::S_RESP))
        else $error("result raised outside response state");

    // Totals move only on an append
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == mrt_pkg::S_EXEC && q_cmd_reg == mrt_pkg::CMD_APPEND)
        |=> ($stable(avail_reg) && $stable(top_reg)))
        else $error("totals changed without append");

    // A missing entry reads back empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == mrt_pkg::STAT_NOENT)
        |-> (!m_found_reg && m_base_reg == 64'd0 && m_len_reg == 64'd0))
        else $error("missing entry reported with data");

endmodule
